FILE: hdl/smf_pkg.sv
// Package for the 3x3 sliding maximum filter.
// Holds configuration register indexes, field widths and reset values.
// No dependencies.
package smf_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    localparam int IMAGE_WIDTH_W  = 11;
    localparam int IMAGE_HEIGHT_W = 16;

    localparam logic [IMAGE_WIDTH_W-1:0]  IMAGE_WIDTH_RESET  = 11'd640;
    localparam logic [IMAGE_HEIGHT_W-1:0] IMAGE_HEIGHT_RESET = 16'd480;

    // Smallest frame dimension the window can work on.
    localparam int MIN_DIM = 3;

endpackage

FILE: hdl/smf_if.sv
// Valid/ready stream interfaces for the 3x3 sliding maximum filter.
// smf_pix_if carries input pixels, smf_max_if carries window results.
// No dependencies.
interface smf_pix_if #(
    parameter int PIXEL_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface smf_max_if #(
    parameter int PIXEL_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] window_max;
    logic                  frame_last;

    modport source (output valid, output window_max, output frame_last, input ready);
    modport sink   (input valid, input window_max, input frame_last, output ready);
endinterface

FILE: hdl/sliding_max_filter_3x3.sv
// Top level of the 3x3 sliding maximum filter (stride one, valid region only).
// Depends on smf_pkg, smf_if.sv, smf_line_buffer and smf_cell.
//
//  channel   direction  payload                   meaning
//  i_pix     in         pixel_value               raster-order greyscale pixel
//  o_max     out        window_max, frame_last    3x3 maximum, end of frame mark
//  i_cfg_*   in         index, data               image_width, image_height
//
// One pixel is taken per clock while the output is not stalled; a result
// passes the line buffer read, the column cell shift and the output register.
// Each stage moves when the next one is empty or moving, so a stalled output
// holds the pipeline without losing items. Reset clears the counters and the
// pipeline; the line buffer is never cleared, since stale entries reach only
// windows that give no result. A configuration write restarts the frame.
module sliding_max_filter_3x3
    import smf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    smf_pix_if.sink               i_pix,
    smf_max_if.source             o_max
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int WW     = (ADDR_W + 1 > IMAGE_WIDTH_W) ? ADDR_W + 1 : IMAGE_WIDTH_W;
    localparam int NCELLS = 3;

    // Configuration and derived frame bounds.
    logic [IMAGE_WIDTH_W-1:0]  r_image_width;
    logic [IMAGE_HEIGHT_W-1:0] r_image_height;
    logic [WW-1:0]             eff_width;
    logic [ADDR_W-1:0]         last_col;
    logic [IMAGE_HEIGHT_W-1:0] last_row;

    always_comb begin
        eff_width = WW'(r_image_width);
        if (eff_width < WW'(MIN_DIM)) begin
            eff_width = WW'(MIN_DIM);
        end
        if (eff_width > WW'(MAX_WIDTH)) begin
            eff_width = WW'(MAX_WIDTH);
        end
        last_col = ADDR_W'(eff_width - WW'(1));
        if (r_image_height < IMAGE_HEIGHT_W'(MIN_DIM)) begin
            last_row = IMAGE_HEIGHT_W'(MIN_DIM - 1);
        end else begin
            last_row = r_image_height - IMAGE_HEIGHT_W'(1);
        end
    end

    // Pipeline control.
    logic r_s1_valid, r_s2_valid, r_o_valid;
    logic en1, en2, en3, accept, adv12;

    assign en3    = !r_o_valid || o_max.ready;
    assign en2    = !r_s2_valid || en3;
    assign en1    = !r_s1_valid || en2;
    assign accept = i_pix.valid && en1;
    assign adv12  = r_s1_valid && en2;

    assign i_pix.ready = en1;

    // Position counters and stage registers.
    logic [ADDR_W-1:0]         r_col;
    logic [IMAGE_HEIGHT_W-1:0] r_row;
    logic [PIXEL_BITS-1:0]     r_s1_pix;
    logic [ADDR_W-1:0]         r_s1_col;
    logic                      r_s1_out_en, r_s1_last, r_s2_last;
    logic [PIXEL_BITS-1:0]     r_o_max;
    logic                      r_o_last;

    // Line buffer words are {row r-2, row r-1} for each column.
    logic [2*PIXEL_BITS-1:0] rd_data;
    logic [PIXEL_BITS-1:0]   top, mid, col_max_tm, col_max;

    smf_line_buffer #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (2 * PIXEL_BITS)
    ) u_line_buffer (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (rd_data),
        .i_wr_en   (adv12),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({mid, r_s1_pix})
    );

    assign top        = rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
    assign mid        = rd_data[PIXEL_BITS-1:0];
    assign col_max_tm = (top > mid) ? top : mid;
    assign col_max    = (col_max_tm > r_s1_pix) ? col_max_tm : r_s1_pix;

    // Column cells: cell 0 holds the newest column, the chain folds the maximum.
    logic [PIXEL_BITS-1:0] cell_data [NCELLS+1];
    logic [PIXEL_BITS-1:0] cell_max  [NCELLS+1];

    assign cell_data[0] = col_max;
    assign cell_max[0]  = '0;

    for (genvar k = 0; k < NCELLS; k++) begin : g_cell
        smf_cell #(
            .PIXEL_BITS (PIXEL_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (adv12),
            .i_data  (cell_data[k]),
            .o_data  (cell_data[k+1]),
            .i_max   (cell_max[k]),
            .o_max   (cell_max[k+1])
        );
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= IMAGE_WIDTH_RESET;
            r_image_height <= IMAGE_HEIGHT_RESET;
            r_col          <= '0;
            r_row          <= '0;
            r_s1_valid     <= 1'b0;
            r_s2_valid     <= 1'b0;
            r_o_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH: begin
                        r_image_width <= i_cfg_data[IMAGE_WIDTH_W-1:0];
                    end
                    CFG_IMAGE_HEIGHT: begin
                        r_image_height <= i_cfg_data[IMAGE_HEIGHT_W-1:0];
                    end
                    default: begin
                    end
                endcase
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                if (r_col == last_col) begin
                    r_col <= '0;
                    r_row <= (r_row == last_row) ? '0 : r_row + IMAGE_HEIGHT_W'(1);
                end else begin
                    r_col <= r_col + ADDR_W'(1);
                end
            end
            if (en1) begin
                r_s1_valid <= i_pix.valid;
            end
            // Items left of column two or above row two give no result.
            if (en2) begin
                r_s2_valid <= r_s1_valid && r_s1_out_en;
            end
            if (en3) begin
                r_o_valid <= r_s2_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix    <= i_pix.pixel_value;
            r_s1_col    <= r_col;
            r_s1_out_en <= (r_row >= IMAGE_HEIGHT_W'(2)) && (r_col >= ADDR_W'(2));
            r_s1_last   <= (r_row == last_row) && (r_col == last_col);
        end
        if (adv12) begin
            r_s2_last <= r_s1_last;
        end
        // The cells shift only when an item moves from the first stage to the second,
        // so they still hold this item's window here.
        if (r_s2_valid && en3) begin
            r_o_max  <= cell_max[NCELLS];
            r_o_last <= r_s2_last;
        end
    end

    assign o_max.valid      = r_o_valid;
    assign o_max.window_max = r_o_max;
    assign o_max.frame_last = r_o_last;

endmodule

FILE: hdl/smf_line_buffer.sv
// Line buffer RAM for the 3x3 sliding maximum filter.
// One write port and one registered read port; each word holds two rows.
// Depends on smf_pkg only through the common project import.
module smf_line_buffer
    import smf_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // The read register holds its word while the reading stage is stalled.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/smf_cell.sv
// One column cell of the window chain for the 3x3 sliding maximum filter.
// Holds the maximum of one window column and folds it into a running maximum.
// Depends on smf_pkg only through the common project import.
module smf_cell
    import smf_pkg::*;
#(
    parameter int PIXEL_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_shift,
    input  logic [PIXEL_BITS-1:0] i_data,
    output logic [PIXEL_BITS-1:0] o_data,
    input  logic [PIXEL_BITS-1:0] i_max,
    output logic [PIXEL_BITS-1:0] o_max
);

    logic [PIXEL_BITS-1:0] r_val;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_val <= i_data;
        end
    end

    assign o_data = r_val;
    assign o_max  = (r_val > i_max) ? r_val : i_max;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for sliding_max_filter_3x3: a short table of frames, then random
// frames under several sizes and both kinds of back-pressure, checked against a 3x3 max model.
// Depends on smf_pkg, smf_if.sv and sliding_max_filter_3x3.sv.
module tb_top;
    import smf_pkg::*;

    localparam int PIX_W = 8;
    localparam int MAX_W = 1024;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT = 2000;
    localparam int NUM_PHASES = 9;

    typedef struct packed {
        logic [PIX_W-1:0] window_max;
        logic             frame_last;
    } t_pooled;

    typedef enum logic {ROW_CFG, ROW_PIX} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
        logic [PIX_W-1:0]      pixel;
        logic                  typed;
        logic [PIX_W-1:0]      t_max;
        logic                  t_last;
    } t_step;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // A hand-computed result travels with its pixel and replaces the model value.
    logic             typed_on;
    logic [PIX_W-1:0] typed_max;
    logic             typed_last;

    smf_pix_if #(.PIXEL_BITS(PIX_W)) pix_ch ();
    smf_max_if #(.PIXEL_BITS(PIX_W)) max_ch ();

    sliding_max_filter_3x3 #(
        .MAX_WIDTH (MAX_W),
        .PIXEL_BITS(PIX_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_ch),
        .o_max      (max_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Model state of the filter.
    logic [IMAGE_WIDTH_W-1:0]  lim_width;
    logic [IMAGE_HEIGHT_W-1:0] lim_height;
    logic [PIX_W-1:0]          older_line [MAX_W];
    logic [PIX_W-1:0]          newer_line [MAX_W];
    logic [PIX_W-1:0]          win [3][3];
    int                        col_pos;
    int                        row_pos;

    t_pooled pooled_q[$];

    int mismatches = 0;
    int pixels_in = 0;
    int results_out = 0;
    int reg_writes = 0;
    int quiet_cycles = 0;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int hold_req = 0;

    t_step directed_steps [22];
    int    plan_w [NUM_PHASES] = '{3, -1, 1, 7, -1, 16, 16'hFFFF, -1, 10};
    int    plan_h [NUM_PHASES] = '{3, -1, 2, 5, -1, 16'hFFFF, 0, -1, 4};
    int    plan_n [NUM_PHASES] = '{90, -1, 60, 100, -1, 80, MAX_W + 8, -1, 120};

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Shifts one pixel through the line stores and the window, and gives the
    // maximum once the whole neighbourhood lies inside the frame.
    task automatic slide_window(input logic [PIX_W-1:0] p, output bit produced,
                                output t_pooled res);
        int w, h, c, r, i, j;
        logic [PIX_W-1:0] top, mid, best;
        w = lim_width;
        if (w < MIN_DIM) w = MIN_DIM;
        if (w > MAX_W) w = MAX_W;
        h = lim_height;
        if (h < MIN_DIM) h = MIN_DIM;
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = (row_pos >= h) ? h - 1 : row_pos;
        top = older_line[c];
        mid = newer_line[c];
        older_line[c] = mid;
        newer_line[c] = p;
        for (i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = p;
        best = '0;
        for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
                if (win[i][j] > best) best = win[i][j];
        produced = (r >= 2 && c >= 2);
        res.window_max = best;
        res.frame_last = (r == h - 1 && c == w - 1);
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        bit      produced;
        t_pooled res;
        t_pooled want;
        if (!i_rst_n) begin
            lim_width = IMAGE_WIDTH_RESET;
            lim_height = IMAGE_HEIGHT_RESET;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win[i][j] = '0;
            col_pos = 0;
            row_pos = 0;
        end else begin
            if (i_cfg_we) begin
                reg_writes++;
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  lim_width = i_cfg_data[IMAGE_WIDTH_W-1:0];
                    CFG_IMAGE_HEIGHT: lim_height = i_cfg_data[IMAGE_HEIGHT_W-1:0];
                    default: ;
                endcase
                // Any register write starts a new frame; the line stores keep their data.
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        win[i][j] = '0;
                col_pos = 0;
                row_pos = 0;
            end
            if (pix_ch.valid && pix_ch.ready) begin
                pixels_in++;
                slide_window(pix_ch.pixel_value, produced, res);
                if (typed_on) begin
                    res.window_max = typed_max;
                    res.frame_last = typed_last;
                    pooled_q.push_back(res);
                end else if (produced) begin
                    pooled_q.push_back(res);
                end
            end
            if (max_ch.valid && max_ch.ready) begin
                results_out++;
                if (pooled_q.size() == 0) begin
                    report_mismatch("result with nothing pending, window_max",
                                    max_ch.window_max, -1);
                end else begin
                    want = pooled_q.pop_front();
                    if (max_ch.window_max !== want.window_max)
                        report_mismatch("window_max", max_ch.window_max, want.window_max);
                    if (max_ch.frame_last !== want.frame_last)
                        report_mismatch("frame_last", max_ch.frame_last, want.frame_last);
                end
            end
            if ((pix_ch.valid && pix_ch.ready) || (max_ch.valid && max_ch.ready) || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles, %0d results pending",
                         QUIET_LIMIT, pooled_q.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Output side: random stalls, plus a long hold-off when one is requested.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        max_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left != 0) begin
                max_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                max_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] p, input logic typed,
                              input logic [PIX_W-1:0] tmax, input logic tlast);
        while ($urandom_range(99) < snd_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel_value <= p;
        typed_on <= typed;
        typed_max <= tmax;
        typed_last <= tlast;
        do @(posedge i_clk); while (!pix_ch.ready);
    endtask

    // Lets the pipeline empty; a pixel that makes no result may still be in flight
    // after the last result, so a settling wait follows.
    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pooled_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        int w, h, n;
        logic [PIX_W-1:0] p;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_IMAGE_WIDTH;
        i_cfg_data <= '0;
        pix_ch.valid <= 1'b0;
        pix_ch.pixel_value <= '0;
        typed_on <= 1'b0;
        typed_max <= '0;
        typed_last <= 1'b0;

        // First frame: a lone bright pixel in the bottom-right corner. Second frame:
        // widths and heights below the minimum, bright pixel in the top-left corner.
        directed_steps = '{
            '{ROW_CFG, CFG_IMAGE_WIDTH,  16'd3, 8'd0,   1'b0, 8'd0,   1'b0},
            '{ROW_CFG, CFG_IMAGE_HEIGHT, 16'd3, 8'd0,   1'b0, 8'd0,   1'b0},
            '{ROW_PIX, CFG_IMAGE_WIDTH,  16'd0, 8'd0,   1'b0, 8'd0,   1'b0},
            '{ROW_PIX, CFG_IMAGE_WIDTH,  16'd0, 8'd0,   1'b0, 8'd0,   1'b0},
            '{ROW_PIX, CFG_IMAGE_WIDTH,  16'd0, 8'd0,   1'b0, 8'd0,   1'b0},
            '{ROW_PIX, CFG_IMAGE_WIDTH,  16'd0, 8'd0,   1'b0, 8'd0,   1'b0},
            '{ROW_PIX, CFG_IMAGE_WIDTH,  16'd0, 8'd0,   1'b0, 8'd0,   1'b0},
            '{ROW_PIX, CFG_IMAGE_WIDTH,  16'd0, 8'd0,   1'b0, 8'd0,   1'b0},
            '{ROW_PIX, CFG_IMAGE_WIDTH,  16'd0, 8'd0,   1'b0, 8'd0,   1'b0},
            '{ROW_PIX, CFG_IMAGE_WIDTH,  16'd0, 8'd0,   1'b0, 8'd0,   1'b0},
            '{ROW_PIX, CFG_IMAGE_WIDTH,  16'd0, 8'd255, 1'b1, 8'd255, 1'b1},
            '{ROW_CFG, CFG_IMAGE_WIDTH,  16'd1, 8'd0,   1'b0, 8'd0,   1'b0},
            '{ROW_CFG, CFG_IMAGE_HEIGHT, 16'd2, 8'd0,   1'b0, 8'd0,   1'b0},
            '{ROW_PIX, CFG_IMAGE_WIDTH,  16'd0, 8'd254, 1'b0, 8'd0,   1'b0},
            '{ROW_PIX, CFG_IMAGE_WIDTH,  16'd0, 8'd1,   1'b0, 8'd0,   1'b0},
            '{ROW_PIX, CFG_IMAGE_WIDTH,  16'd0, 8'd2,   1'b0, 8'd0,   1'b0},
            '{ROW_PIX, CFG_IMAGE_WIDTH,  16'd0, 8'd3,   1'b0, 8'd0,   1'b0},
            '{ROW_PIX, CFG_IMAGE_WIDTH,  16'd0, 8'd4,   1'b0, 8'd0,   1'b0},
            '{ROW_PIX, CFG_IMAGE_WIDTH,  16'd0, 8'd5,   1'b0, 8'd0,   1'b0},
            '{ROW_PIX, CFG_IMAGE_WIDTH,  16'd0, 8'd6,   1'b0, 8'd0,   1'b0},
            '{ROW_PIX, CFG_IMAGE_WIDTH,  16'd0, 8'd7,   1'b0, 8'd0,   1'b0},
            '{ROW_PIX, CFG_IMAGE_WIDTH,  16'd0, 8'd8,   1'b1, 8'd254, 1'b1}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        snd_idle_pct = 24;
        rcv_idle_pct = 60;
        foreach (directed_steps[k]) begin
            if (directed_steps[k].kind == ROW_CFG) begin
                wait_idle();
                write_reg(directed_steps[k].index, directed_steps[k].data);
            end else begin
                send_pixel(directed_steps[k].pixel, directed_steps[k].typed,
                           directed_steps[k].t_max, directed_steps[k].t_last);
            end
        end

        // Three phases per idling mode. Fixed sizes cover the minimum, clamped,
        // tallest and widest frames; the rest are small random frames that often
        // end mid-frame, so the next register write also restarts a frame.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph / 3)
                0: begin
                    snd_idle_pct = 24;
                    rcv_idle_pct = 60;
                end
                1: begin
                    snd_idle_pct = 60;
                    rcv_idle_pct = 24;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            if (plan_w[ph] < 0) begin
                w = $urandom_range(12, 3);
                h = $urandom_range(5, 3);
                n = w * h * $urandom_range(3, 1) + $urandom_range(w, 0);
            end else begin
                w = plan_w[ph];
                h = plan_h[ph];
                n = plan_n[ph];
            end
            wait_idle();
            write_reg(CFG_IMAGE_WIDTH, w[CFG_DATA_W-1:0]);
            write_reg(CFG_IMAGE_HEIGHT, h[CFG_DATA_W-1:0]);
            // The last phase starts with a long output stall so the pipeline fills.
            if (ph == NUM_PHASES - 1) hold_req = 200;
            for (int k = 0; k < n; k++) begin
                case ($urandom_range(3))
                    0: p = PIX_W'($urandom_range(3));
                    1: p = PIX_W'($urandom_range(255, 252));
                    default: p = PIX_W'($urandom_range(255));
                endcase
                send_pixel(p, 1'b0, '0, 1'b0);
            end
        end
        wait_idle();

        $display("Run covered %0d pixels and %0d window results over %0d register writes,",
                 pixels_in, results_out, reg_writes);
        $display("with clamped, tallest and 1024-wide frames and a long output stall.");
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/smf_pkg.sv
hdl/smf_if.sv
hdl/smf_line_buffer.sv
hdl/smf_cell.sv
hdl/sliding_max_filter_3x3.sv
sim/tb_top.sv
